/* rtl/pir_swing_motion_detector_core_assert.svh */
// Assertion macros shared by the motion detector RTL.
// Both sample on the rising edge of clk and are switched off while rst_n is low.
`ifndef PIR_SWING_MOTION_DETECTOR_CORE_ASSERT_SVH
`define PIR_SWING_MOTION_DETECTOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSMD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psmd assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define PSMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psmd assertion failed one cycle later");

`endif

/* rtl/psmd_pkg.sv */
// ----------------------------------------------------------------------------
// psmd_pkg: shared types and constants of the PIR swing motion detector
// Word layouts, opcodes, register indexes and reset values.
// ----------------------------------------------------------------------------
package psmd_pkg;

  localparam int RAW_WIDTH    = 16;
  localparam int SAMPLE_SHIFT = 7;
  localparam int WIN_W        = RAW_WIDTH - SAMPLE_SHIFT;

  localparam int THR_W   = 9;
  localparam int SWING_W = 3;
  localparam int QUIET_W = 10;
  localparam int HOLD_W  = 10;
  localparam int HB_W    = 8;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 3;

  localparam logic [WIN_W-1:0]   WIN_RESET   = WIN_W'(128);
  localparam logic [WIN_W-1:0]   EXT_RESET   = WIN_W'(130);
  localparam logic [SWING_W-1:0] SWING_MAX   = SWING_W'(7);

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(3);
  localparam logic [SWING_W-1:0] TRIG_RESET  = SWING_W'(4);
  localparam logic [QUIET_W-1:0] QUIET_RESET = QUIET_W'(166);
  localparam logic [HOLD_W-1:0]  HOLD_RESET  = HOLD_W'(500);
  localparam logic [HB_W-1:0]    HB_RESET    = HB_W'(86);

  localparam logic [CFG_IDX_W-1:0] CFG_SWING_THRESHOLD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SWINGS_TO_TRIGGER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_LIMIT       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS        = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_PERIOD  = CFG_IDX_W'(4);

  typedef enum logic [0:0] {
    OP_TICK   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                  opcode;
    logic [RAW_WIDTH-1:0] raw_sample;
  } in_t;

  typedef struct packed {
    logic relay_active;
    logic led_burst;
    logic swing_marker;
    logic heartbeat;
  } out_t;

  typedef struct packed {
    logic [THR_W-1:0]   swing_threshold;
    logic [SWING_W-1:0] swings_to_trigger;
    logic [QUIET_W-1:0] quiet_limit;
    logic [HOLD_W-1:0]  hold_ticks;
    logic [HB_W-1:0]    heartbeat_period;
  } cfg_t;

endpackage

/* rtl/pir_swing_motion_detector_core.sv */
// ----------------------------------------------------------------------------
// pir_swing_motion_detector_core: PIR swing motion detector, top level
// Input register, detector engine, configuration registers, result register.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one word per cycle while not stalled: a timer
//   tick (opcode 0) or a converter sample (opcode 1). A word is taken when
//   in_valid is high and in_stall is low. Every word gives exactly one result
//   word on the output channel, taken when out_valid is high and out_stall is low.
//   The word is first held in the input register; when it advances, the engine
//   updates the detector state and loads the result register together.
//   Throughput is one word per cycle when out_stall is low; the input register and
//   the result register let a new word enter while a finished result still waits.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_stall rises only when both are occupied.
//   Configuration writes are always ready and are meant for idle periods.
//   After a synchronous reset both channels are empty, the registers hold
//   their defaults and the detector state is back at its start values.
// ----------------------------------------------------------------------------
module pir_swing_motion_detector_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  psmd_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output psmd_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psmd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import psmd_pkg::*;

  in_t  in_r, in_nxt;
  logic in_valid_r, in_valid_nxt;
  out_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  logic advance, in_take;
  cfg_t cfg;
  out_t result;

  assign cfg_ready = 1'b1;

  psmd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  psmd_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_r),
    .cfg    (cfg),
    .result (result)
  );

  // The held word moves on whenever the result register is free or emptying.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_nxt        = in_r;
    in_valid_nxt  = in_valid_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (in_take) begin
      in_nxt       = in_data;
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_nxt       = result;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "pir_swing_motion_detector_core_assert.svh"

  `PSMD_ASSERT_NEXT(a_advance_fills, advance, out_valid_r && (out_r == $past(result)))
  `PSMD_ASSERT_SAME(a_stall_only_full, in_stall, in_valid_r && out_valid_r)
  `PSMD_ASSERT_NEXT(a_take_holds, in_take, in_valid_r)

endmodule

/* rtl/psmd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// psmd_cfg_regs: configuration register file
// Holds the five detector settings; a write keeps the low bits of the data.
// ----------------------------------------------------------------------------
module psmd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [psmd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [psmd_pkg::CFG_DATA_W-1:0] wr_data,
  output psmd_pkg::cfg_t                 cfg
);
  import psmd_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_SWING_THRESHOLD:   cfg_nxt.swing_threshold   = wr_data[THR_W-1:0];
        CFG_SWINGS_TO_TRIGGER: cfg_nxt.swings_to_trigger = wr_data[SWING_W-1:0];
        CFG_QUIET_LIMIT:       cfg_nxt.quiet_limit       = wr_data[QUIET_W-1:0];
        CFG_HOLD_TICKS:        cfg_nxt.hold_ticks        = wr_data[HOLD_W-1:0];
        CFG_HEARTBEAT_PERIOD:  cfg_nxt.heartbeat_period  = wr_data[HB_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swing_threshold   <= THR_RESET;
      cfg_r.swings_to_trigger <= TRIG_RESET;
      cfg_r.quiet_limit       <= QUIET_RESET;
      cfg_r.hold_ticks        <= HOLD_RESET;
      cfg_r.heartbeat_period  <= HB_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/psmd_engine.sv */
// ----------------------------------------------------------------------------
// psmd_engine: detector state and single-pass update
// Applies one tick or sample word to the detector state and forms its result.
// ----------------------------------------------------------------------------
module psmd_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  psmd_pkg::in_t  item,
  input  psmd_pkg::cfg_t cfg,
  output psmd_pkg::out_t result
);
  import psmd_pkg::*;

  localparam int DW    = WIN_W + 2;
  localparam int CMP_W = (WIN_W > THR_W) ? WIN_W : THR_W;

  logic [WIN_W-1:0]   newest_r, newest_nxt, middle_r, middle_nxt, oldest_r, oldest_nxt;
  logic [WIN_W-1:0]   peak_r, peak_nxt, valley_r, valley_nxt;
  logic [SWING_W-1:0] swing_r, swing_nxt;
  logic [QUIET_W-1:0] quiet_r, quiet_nxt;
  logic [HOLD_W-1:0]  hold_r, hold_nxt;
  logic [HB_W-1:0]    hb_count_r, hb_count_nxt;
  logic               hb_level_r, hb_level_nxt;
  logic               armed_r, armed_nxt;
  logic               marker_r, marker_nxt;

  logic [WIN_W-1:0] sample_val;
  logic [DW-1:0]    d2, span;
  logic             flat;
  logic [WIN_W-1:0] pk, vl, swing_size;
  logic [SWING_W-1:0] swing_inc;
  logic [HB_W-1:0]  hb_inc;
  logic             relay, burst;
  logic             marker_set;

  assign sample_val = item.raw_sample[RAW_WIDTH-1:SAMPLE_SHIFT];

  // Second difference and span of the window once the sample is pushed in.
  assign d2   = {2'b00, sample_val} + {2'b00, middle_r} - {1'b0, newest_r, 1'b0};
  assign span = {2'b00, middle_r} - {2'b00, sample_val};
  assign flat = (span == '0) || (span == DW'(1)) || (span == '1);

  always_comb begin
    pk = peak_r;
    vl = valley_r;
    if (d2[DW-1]) pk = newest_r;
    if (!d2[DW-1] && (d2 != '0)) vl = newest_r;
  end

  assign swing_size = (pk >= vl) ? (pk - vl) : (vl - pk);
  assign swing_inc  = (swing_r < SWING_MAX) ? (swing_r + SWING_W'(1)) : SWING_MAX;
  assign hb_inc     = hb_count_r + HB_W'(1);

  always_comb begin
    newest_nxt   = newest_r;
    middle_nxt   = middle_r;
    oldest_nxt   = oldest_r;
    peak_nxt     = peak_r;
    valley_nxt   = valley_r;
    swing_nxt    = swing_r;
    quiet_nxt    = quiet_r;
    hold_nxt     = hold_r;
    hb_count_nxt = hb_count_r;
    hb_level_nxt = hb_level_r;
    armed_nxt    = armed_r;
    marker_nxt   = marker_r;
    burst        = 1'b0;
    unique case (item.opcode)
      OP_TICK: begin
        if (hb_inc >= cfg.heartbeat_period) begin
          hb_count_nxt = '0;
          hb_level_nxt = !hb_level_r;
        end else begin
          hb_count_nxt = hb_inc;
        end
        marker_nxt = 1'b0;
        if (quiet_r < cfg.quiet_limit) begin
          quiet_nxt = quiet_r + QUIET_W'(1);
        end else begin
          // Quiet timeout: drift the window and forget the swing history.
          quiet_nxt  = cfg.quiet_limit;
          oldest_nxt = middle_r;
          middle_nxt = newest_r;
          swing_nxt  = '0;
          peak_nxt   = valley_r;
        end
        if (hold_r >= cfg.hold_ticks) begin
          hold_nxt = cfg.hold_ticks;
        end else begin
          hold_nxt = hold_r + HOLD_W'(1);
          burst    = 1'b1;
        end
        armed_nxt = 1'b1;
      end
      OP_SAMPLE: begin
        if (armed_r) begin
          armed_nxt = 1'b0;
          if (sample_val != newest_r) begin
            oldest_nxt = middle_r;
            middle_nxt = newest_r;
            newest_nxt = sample_val;
            if (flat) begin
              peak_nxt   = pk;
              valley_nxt = vl;
              if (CMP_W'(swing_size) > CMP_W'(cfg.swing_threshold)) begin
                swing_nxt  = swing_inc;
                quiet_nxt  = '0;
                marker_nxt = 1'b1;
                burst      = 1'b1;
                if (swing_inc >= cfg.swings_to_trigger) begin
                  hold_nxt  = '0;
                  swing_nxt = '0;
                  peak_nxt  = vl;
                end
              end
            end
          end
        end
      end
      default: begin
        burst = 1'b0;
      end
    endcase
  end

  // A tick reports the relay as found on entry, a sample as left afterwards.
  assign relay = (item.opcode == OP_TICK) ? (hold_r < cfg.hold_ticks)
                                          : (hold_nxt < cfg.hold_ticks);

  assign result.relay_active = relay;
  assign result.led_burst    = burst;
  assign result.swing_marker = marker_nxt;
  assign result.heartbeat    = hb_level_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r   <= WIN_RESET;
      middle_r   <= WIN_RESET;
      oldest_r   <= WIN_RESET;
      peak_r     <= EXT_RESET;
      valley_r   <= EXT_RESET;
      swing_r    <= '0;
      quiet_r    <= '0;
      hold_r     <= '0;
      hb_count_r <= '0;
      hb_level_r <= 1'b1;
      armed_r    <= 1'b1;
      marker_r   <= 1'b0;
    end else if (step) begin
      newest_r   <= newest_nxt;
      middle_r   <= middle_nxt;
      oldest_r   <= oldest_nxt;
      peak_r     <= peak_nxt;
      valley_r   <= valley_nxt;
      swing_r    <= swing_nxt;
      quiet_r    <= quiet_nxt;
      hold_r     <= hold_nxt;
      hb_count_r <= hb_count_nxt;
      hb_level_r <= hb_level_nxt;
      armed_r    <= armed_nxt;
      marker_r   <= marker_nxt;
    end
  end

  // A sample that raises the marker from low must be a counted swing.
  assign marker_set = (item.opcode == OP_SAMPLE) && !marker_r && result.swing_marker;

`include "pir_swing_motion_detector_core_assert.svh"

  `PSMD_ASSERT_NEXT(a_tick_arms, step && (item.opcode == OP_TICK), armed_r && !marker_r)
  `PSMD_ASSERT_NEXT(a_sample_disarms, step && (item.opcode == OP_SAMPLE), !armed_r)
  `PSMD_ASSERT_NEXT(a_idle_holds, !step, $stable(newest_r) && $stable(hold_r) && $stable(swing_r))
  `PSMD_ASSERT_SAME(a_marker_burst, step && marker_set, result.led_burst)

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the PIR swing motion detector core
// Sends timer ticks and converter samples through the stall handshake under a
// range of register settings, with random gaps and receiver stalls, and checks
// every result word against a typed value or a behavioural detector copy kept here.
// ----------------------------------------------------------------------------
module testbench;
  import psmd_pkg::*;

  localparam int DIR_ROWS     = 25;
  localparam int NUM_PHASES   = 10;
  localparam int RAND_WORDS   = 1150;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTS   = 50;

  typedef struct packed {
    op_t                  opcode;
    logic [RAW_WIDTH-1:0] raw;
    logic                 typed;
    out_t                 result;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  calm_mode = 1'b0;

  // Detector state as the bench sees it
  cfg_t               regs_m;
  logic [WIN_W-1:0]   win_new, win_mid, win_old, peak_lvl, valley_lvl;
  logic [SWING_W-1:0] swings;
  logic [QUIET_W-1:0] quiet_ticks;
  logic [HOLD_W-1:0]  hold_ticks_done;
  logic [HB_W-1:0]    hb_ticks;
  logic               hb_lvl, armed_m, marker_m;

  out_t expected_words [$];
  int   err_count     = 0;
  int   counted_words = 0;
  int   stall_run     = 0;

  // Reset defaults first, then a hand-built walk through the swing detector.
  // Expected words are typed in only where they are obvious.
  dir_row_t dir_plan [DIR_ROWS] = '{
    '{OP_TICK,   16'h0000, 1'b1, 4'b1101},
    '{OP_SAMPLE, 16'hFFFF, 1'b1, 4'b1001},
    '{OP_SAMPLE, 16'h0000, 1'b1, 4'b1001},
    '{OP_TICK,   16'h0000, 1'b1, 4'b1101},
    '{OP_SAMPLE, 16'h0000, 1'b0, 4'b0000},
    '{OP_TICK,   16'h0000, 1'b0, 4'b0000},
    '{OP_SAMPLE, 16'h007F, 1'b0, 4'b0000},
    '{OP_TICK,   16'h0000, 1'b0, 4'b0000},
    '{OP_SAMPLE, 16'hFF80, 1'b0, 4'b0000},
    '{OP_TICK,   16'h0000, 1'b0, 4'b0000},
    '{OP_SAMPLE, 16'h0001, 1'b0, 4'b0000},
    '{OP_TICK,   16'h0000, 1'b0, 4'b0000},
    '{OP_SAMPLE, 16'hFF85, 1'b0, 4'b0000},
    '{OP_TICK,   16'h0000, 1'b0, 4'b0000},
    '{OP_SAMPLE, 16'h0000, 1'b0, 4'b0000},
    '{OP_TICK,   16'h0000, 1'b0, 4'b0000},
    '{OP_SAMPLE, 16'hFFFF, 1'b0, 4'b0000},
    '{OP_TICK,   16'h0000, 1'b0, 4'b0000},
    '{OP_SAMPLE, 16'h0040, 1'b0, 4'b0000},
    '{OP_TICK,   16'h0000, 1'b0, 4'b0000},
    '{OP_SAMPLE, 16'hFFC0, 1'b0, 4'b0000},
    '{OP_TICK,   16'h0000, 1'b0, 4'b0000},
    '{OP_SAMPLE, 16'h0000, 1'b0, 4'b0000},
    '{OP_TICK,   16'h0000, 1'b0, 4'b0000},
    '{OP_SAMPLE, 16'h8000, 1'b0, 4'b0000}
  };

  pir_swing_motion_detector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #6400000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_bit(input string name, input logic got, input logic want);
    if (got !== want) report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
  endtask

  function automatic void reset_detector();
    regs_m.swing_threshold   = THR_RESET;
    regs_m.swings_to_trigger = TRIG_RESET;
    regs_m.quiet_limit       = QUIET_RESET;
    regs_m.hold_ticks        = HOLD_RESET;
    regs_m.heartbeat_period  = HB_RESET;
    win_new         = WIN_RESET;
    win_mid         = WIN_RESET;
    win_old         = WIN_RESET;
    peak_lvl        = EXT_RESET;
    valley_lvl      = EXT_RESET;
    swings          = '0;
    quiet_ticks     = '0;
    hold_ticks_done = '0;
    hb_ticks        = '0;
    hb_lvl          = 1'b1;
    armed_m         = 1'b1;
    marker_m        = 1'b0;
  endfunction

  // Advances the detector by one word and returns the result word it gives.
  function automatic out_t detector_step(input in_t w);
    out_t             res;
    logic [WIN_W-1:0] v;
    int               d2, span, pv_gap;
    logic             relay, burst;
    burst = 1'b0;
    if (w.opcode == OP_TICK) begin
      hb_ticks = hb_ticks + HB_W'(1);
      if (hb_ticks >= regs_m.heartbeat_period) begin
        hb_ticks = '0;
        hb_lvl   = ~hb_lvl;
      end
      marker_m = 1'b0;
      if (quiet_ticks < regs_m.quiet_limit) begin
        quiet_ticks = quiet_ticks + QUIET_W'(1);
      end else begin
        // Quiet timeout: the window ages and the swing history is dropped.
        quiet_ticks = regs_m.quiet_limit;
        win_old     = win_mid;
        win_mid     = win_new;
        swings      = '0;
        peak_lvl    = valley_lvl;
      end
      if (hold_ticks_done >= regs_m.hold_ticks) begin
        hold_ticks_done = regs_m.hold_ticks;
        relay = 1'b0;
      end else begin
        hold_ticks_done = hold_ticks_done + HOLD_W'(1);
        relay = 1'b1;
        burst = 1'b1;
      end
      armed_m = 1'b1;
    end else begin
      if (armed_m) begin
        armed_m = 1'b0;
        v = WIN_W'(w.raw_sample >> SAMPLE_SHIFT);
        if (v != win_new) begin
          win_old = win_mid;
          win_mid = win_new;
          win_new = v;
          d2   = int'(win_new) + int'(win_old) - 2 * int'(win_mid);
          span = int'(win_old) - int'(win_new);
          if (span >= -1 && span <= 1) begin
            if (d2 < 0) peak_lvl = win_mid;
            if (d2 > 0) valley_lvl = win_mid;
            pv_gap = int'(peak_lvl) - int'(valley_lvl);
            if (pv_gap < 0) pv_gap = -pv_gap;
            if (pv_gap > int'(regs_m.swing_threshold)) begin
              if (swings < SWING_MAX) swings = swings + SWING_W'(1);
              quiet_ticks = '0;
              marker_m    = 1'b1;
              burst       = 1'b1;
              if (swings >= regs_m.swings_to_trigger) begin
                hold_ticks_done = '0;
                swings          = '0;
                peak_lvl        = valley_lvl;
              end
            end
          end
        end
      end
      relay = (hold_ticks_done < regs_m.hold_ticks);
    end
    res.relay_active = relay;
    res.led_burst    = burst;
    res.swing_marker = marker_m;
    res.heartbeat    = hb_lvl;
    return res;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_mode || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic in_t tick_word();
    in_t w;
    w.opcode     = OP_TICK;
    w.raw_sample = RAW_WIDTH'($urandom);
    return w;
  endfunction

  function automatic in_t sample_of(input logic [WIN_W-1:0] v);
    in_t w;
    w.opcode     = OP_SAMPLE;
    w.raw_sample = {v, SAMPLE_SHIFT'($urandom)};
    return w;
  endfunction

  task automatic send_word(input in_t w, input logic typed, input out_t typed_res);
    int   gap;
    out_t predicted;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Unarmed samples are merely ignored, so they do not count as real work.
    if (!(w.opcode == OP_SAMPLE && !armed_m)) counted_words++;
    predicted = detector_step(w);
    expected_words.push_back(typed ? typed_res : predicted);
  endtask

  task automatic send(input in_t w);
    send_word(w, 1'b0, '0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SWING_THRESHOLD:   regs_m.swing_threshold   = val[THR_W-1:0];
      CFG_SWINGS_TO_TRIGGER: regs_m.swings_to_trigger = val[SWING_W-1:0];
      CFG_QUIET_LIMIT:       regs_m.quiet_limit       = val[QUIET_W-1:0];
      CFG_HOLD_TICKS:        regs_m.hold_ticks        = val[HOLD_W-1:0];
      CFG_HEARTBEAT_PERIOD:  regs_m.heartbeat_period  = val[HB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] thr, trig, quiet, hold, hb,
                               input logic stray);
    write_reg(CFG_SWING_THRESHOLD, thr);
    write_reg(CFG_SWINGS_TO_TRIGGER, trig);
    write_reg(CFG_QUIET_LIMIT, quiet);
    write_reg(CFG_HOLD_TICKS, hold);
    write_reg(CFG_HEARTBEAT_PERIOD, hb);
    // An index past the last register must leave everything alone.
    if (stray)
      write_reg(CFG_IDX_W'($urandom_range(int'(CFG_HEARTBEAT_PERIOD) + 1,
                                          (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Alternating low and high samples, each after one or two ticks, with the swing size
  // usually placed close to the threshold.
  task automatic swing_burst();
    logic [WIN_W-1:0] lo, hi, v;
    int               amp, jitter, reps;
    if ($urandom_range(0, 99) < 70) begin
      jitter = $urandom_range(0, 4);
      amp    = int'(regs_m.swing_threshold) + jitter - 1;
    end else begin
      amp = $urandom_range(0, 511);
    end
    if (amp < 0) amp = 0;
    if (amp > 511) amp = 511;
    lo   = WIN_W'($urandom_range(0, 511 - amp));
    hi   = lo + WIN_W'(amp);
    reps = $urandom_range(3, 12);
    for (int i = 0; i < reps; i++) begin
      send(tick_word());
      if ($urandom_range(0, 99) < 15) send(tick_word());
      v = (i % 2 == 1) ? hi : lo;
      if ($urandom_range(0, 99) < 20) begin
        if (v < 511 && $urandom_range(0, 1) == 1) v = v + WIN_W'(1);
        else if (v > 0) v = v - WIN_W'(1);
      end
      send(sample_of(v));
    end
  endtask

  task automatic broken_sequence();
    logic [WIN_W-1:0] v;
    v = WIN_W'($urandom);
    send(tick_word());
    send(sample_of(v));
    send(sample_of(WIN_W'($urandom)));
    send(tick_word());
    send(sample_of(v));
  endtask

  task automatic run_random(input int quota);
    int   start, r, n;
    in_t  w;
    start = counted_words;
    while (counted_words - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        swing_burst();
      end else if (r < 75) begin
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(20, 80);
        repeat (n) send(tick_word());
      end else if (r < 85) begin
        broken_sequence();
      end else begin
        w.opcode     = op_t'($urandom_range(0, 1));
        w.raw_sample = RAW_WIDTH'($urandom);
        send(w);
      end
    end
  endtask

  // Receiver stalls: mostly short runs, now and then a long one.
  always @(posedge clk) begin
    if (!rst_n || calm_mode) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run = stall_run - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 35);
      stall_run = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3) : $urandom_range(8, 40);
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word arrived with nothing expected");
      end else begin
        want = expected_words.pop_front();
        check_bit("relay_active", out_data.relay_active, want.relay_active);
        check_bit("led_burst", out_data.led_burst, want.led_burst);
        check_bit("swing_marker", out_data.swing_marker, want.swing_marker);
        check_bit("heartbeat", out_data.heartbeat, want.heartbeat);
      end
    end
  end

  initial begin
    in_t w;
    reset_detector();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int row = 0; row < DIR_ROWS; row++) begin
      w.opcode     = dir_plan[row].opcode;
      w.raw_sample = dir_plan[row].raw;
      send_word(w, dir_plan[row].typed, dir_plan[row].result);
    end
    settle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: apply_setting('0, '0, '0, '0, '0, 1'b0);
        1: apply_setting(10'd511, 10'd7, 10'd1023, 10'd1023, 10'd255, 1'b0);
        // Values wider than the registers keep only their low bits.
        2: apply_setting('1, '1, '1, '1, '1, 1'b1);
        3: apply_setting(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 1'b0);
        4: apply_setting(CFG_DATA_W'(THR_RESET), CFG_DATA_W'(TRIG_RESET),
                         CFG_DATA_W'(QUIET_RESET), CFG_DATA_W'(HOLD_RESET),
                         CFG_DATA_W'(HB_RESET), 1'b0);
        default: begin
          apply_setting(($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                    : CFG_DATA_W'($urandom_range(0, 40)),
                        CFG_DATA_W'($urandom_range(0, 15)),
                        CFG_DATA_W'($urandom_range(0, 60)),
                        CFG_DATA_W'($urandom_range(0, 100)),
                        CFG_DATA_W'($urandom_range(0, 20)),
                        ($urandom_range(0, 1) == 1));
        end
      endcase
      calm_mode <= (phase % 4 == 3);
      run_random(RAND_WORDS / NUM_PHASES);
      settle();
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
